/* src/wopi_pkg.sv */
// wopi_pkg: shared types, widths, register codes and constants
// of the wheel odometry pose integrator. Depends on nothing.
`timescale 1ns / 1ps
package wopi_pkg;

  // default width of a wrapped total difference
  localparam int DIST_WIDTH_DEF = 32;

  // field and datapath widths
  localparam int WORD_W   = 32;
  localparam int REG_W    = 23;
  localparam int DELTA_W  = 34;
  localparam int SUM_W    = 36;
  localparam int MULB_W   = 32;
  localparam int PROD_W   = SUM_W + MULB_W;
  localparam int DIV_W    = 82;
  localparam int DEN_W    = 26;
  localparam int DVS_W    = DEN_W + 16;
  localparam int CORD_W   = 34;
  localparam int CORD_N   = 30;
  localparam int KPART_W  = 23;

  // radians to binary angle, 16 fractional bits, split for the multiplier
  localparam logic [63:0] RAD_TO_BAM = 64'd44798133900178;
  localparam logic [KPART_W-1:0] K_LO = RAD_TO_BAM[KPART_W-1:0];
  localparam logic [KPART_W-1:0] K_HI = RAD_TO_BAM[2*KPART_W-1:KPART_W];

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CORD_W:0]   ONE_Q30     = 35'sd1073741824;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TRACK_SPAN   = 2'd0,
    REG_BASE_EXTRA   = 2'd1,
    REG_MECANUM_MODE = 2'd2
  } reg_index_t;

  // one classified report on its way from front to back
  typedef struct packed {
    logic                    mecanum;
    logic signed [SUM_W-1:0] s_all;
    logic signed [SUM_W-1:0] ym;
    logic signed [SUM_W-1:0] num;
  } work_t;

  // cordic arctangent table, binary angle units
  function automatic logic [WORD_W-1:0] cordic_atan(input logic [4:0] idx);
    logic [WORD_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/wopi_front.sv */
// wopi_front: accepts reports, picks step or total-difference deltas,
// forms kinematic sums and queues them. Depends on wopi_pkg.
`timescale 1ns / 1ps
module wopi_front #(
  parameter int DIST_WIDTH = wopi_pkg::DIST_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                mecanum_mode,
  input  logic [31:0]         sequence_req,
  input  logic signed [31:0]  left_front_total,
  input  logic signed [31:0]  left_back_total,
  input  logic signed [31:0]  right_front_total,
  input  logic signed [31:0]  right_back_total,
  input  logic signed [31:0]  left_front_step,
  input  logic signed [31:0]  left_back_step,
  input  logic signed [31:0]  right_front_step,
  input  logic signed [31:0]  right_back_step,
  output logic                q_valid,
  output wopi_pkg::work_t     q_data,
  input  logic                q_pop
);

  localparam int DW = wopi_pkg::DELTA_W;
  localparam int SW = wopi_pkg::SUM_W;

  logic               have_prev;
  logic [31:0]        prev_seq;
  logic signed [31:0] prev_tot [4];
  logic signed [31:0] tot [4];
  logic signed [31:0] stp [4];
  logic signed [32:0] diff [4];
  logic signed [DW-1:0] tdiff [4];
  logic signed [DW-1:0] d [4];
  logic signed [SW-1:0] e [4];
  logic               use_totals;
  logic               accept;
  wopi_pkg::work_t    rec;

  wopi_pkg::work_t    entry [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign tot[0] = left_front_total;
  assign tot[1] = left_back_total;
  assign tot[2] = right_front_total;
  assign tot[3] = right_back_total;
  assign stp[0] = left_front_step;
  assign stp[1] = left_back_step;
  assign stp[2] = right_front_step;
  assign stp[3] = right_back_step;

  assign accept     = push && !full;
  assign use_totals = have_prev && ((sequence_req - prev_seq) != 32'd1);

  // wheel deltas, total differences wrapped to DIST_WIDTH bits
  for (genvar k = 0; k < 4; k++) begin : g_delta
    assign diff[k] = 33'(tot[k]) - 33'(prev_tot[k]);
    if (DIST_WIDTH >= 33) begin : g_wide
      assign tdiff[k] = DW'(diff[k]);
    end else begin : g_wrap
      assign tdiff[k] = DW'($signed(diff[k][DIST_WIDTH-1:0]));
    end
    assign d[k] = use_totals ? tdiff[k] : DW'(stp[k]);
    assign e[k] = SW'(d[k]);
  end

  // kinematic sums, lateral term zero for differential drive
  always_comb begin
    rec.mecanum = mecanum_mode;
    rec.s_all   = e[0] + e[1] + e[2] + e[3];
    rec.ym      = mecanum_mode ? (e[1] + e[3] - e[0] - e[2]) : '0;
    rec.num     = mecanum_mode ? (e[1] + e[2] - e[0] - e[3])
                               : (e[2] + e[3] - e[0] - e[1]);
  end

  // previous report
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_seq  <= '0;
      for (int k = 0; k < 4; k++) prev_tot[k] <= '0;
    end else if (accept) begin
      have_prev <= 1'b1;
      prev_seq  <= sequence_req;
      for (int k = 0; k < 4; k++) prev_tot[k] <= tot[k];
    end
  end

  // two-word queue toward the back
  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) entry[wr_ptr] <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= !wr_ptr;
      if (q_pop && q_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(accept) - 2'(q_pop && q_valid);
    end
  end

endmodule

/* src/wopi_divider.sv */
// wopi_divider: restoring divider, one quotient bit per cycle,
// keeps the low 32 quotient bits. Depends on wopi_pkg.
`timescale 1ns / 1ps
module wopi_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wopi_pkg::DIV_W-1:0]    dividend,
  input  logic [wopi_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [31:0]                   quotient
);

  localparam int NW = wopi_pkg::DIV_W;
  localparam int VW = wopi_pkg::DVS_W;
  localparam int CW = $clog2(NW);

  logic          run;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num_sh;
  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, num_sh[NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh   <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (run) begin
      num_sh   <= num_sh << 1;
      rem      <= fits ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      quotient <= {quotient[30:0], fits};
    end
  end

endmodule

/* src/wopi_cordic.sv */
// wopi_cordic: iterative rotation cordic, one step per cycle, gives
// clamped Q1.30 cosine and sine of a binary angle. Depends on wopi_pkg.
`timescale 1ns / 1ps
module wopi_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam int XW = wopi_pkg::CORD_W;

  logic                 run;
  logic                 fin;
  logic                 flip;
  logic [4:0]           idx;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [XW-1:0] z;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] at;
  logic                 flip_in;
  logic [31:0]          ang_in;
  logic signed [XW:0]   xf;
  logic signed [XW:0]   yf;

  assign flip_in = (angle > 32'h40000000) && (angle < 32'hC0000000);
  assign ang_in  = flip_in ? angle + 32'h80000000 : angle;
  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = XW'(wopi_pkg::cordic_atan(idx));
  assign xf = flip ? -(XW+1)'(x) : (XW+1)'(x);
  assign yf = flip ? -(XW+1)'(y) : (XW+1)'(y);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        run <= 1'b1;
        idx <= '0;
      end else if (run) begin
        idx <= idx + 1'b1;
        if (idx == 5'(wopi_pkg::CORD_N - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // micro-rotations and clamped result
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= wopi_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= XW'($signed(ang_in));
      flip <= flip_in;
    end else if (run) begin
      if (!z[XW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
    if (fin) begin
      priority if (xf > wopi_pkg::ONE_Q30) cos_q <= 32'(wopi_pkg::ONE_Q30);
      else if (xf < -wopi_pkg::ONE_Q30)    cos_q <= 32'(-wopi_pkg::ONE_Q30);
      else                                 cos_q <= 32'(xf);
      priority if (yf > wopi_pkg::ONE_Q30) sin_q <= 32'(wopi_pkg::ONE_Q30);
      else if (yf < -wopi_pkg::ONE_Q30)    sin_q <= 32'(-wopi_pkg::ONE_Q30);
      else                                 sin_q <= 32'(yf);
    end
  end

endmodule

/* src/wopi_back.sv */
// wopi_back: sequencer that turns queued words into heading change and
// pose update, then holds the result word. Depends on wopi_pkg, wopi_divider,
// wopi_cordic.
`timescale 1ns / 1ps
module wopi_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [22:0]          track_span,
  input  logic [22:0]          base_extra,
  input  logic                 q_valid,
  input  wopi_pkg::work_t      q_data,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   pose_x,
  output logic signed [31:0]   pose_y,
  output logic signed [31:0]   heading,
  output logic signed [31:0]   orient_z,
  output logic signed [31:0]   orient_w
);

  localparam int SW = wopi_pkg::SUM_W;
  localparam int BW = wopi_pkg::MULB_W;
  localparam int PW = wopi_pkg::PROD_W;
  localparam int NW = wopi_pkg::DIV_W;
  localparam int DNW = wopi_pkg::DEN_W;
  localparam int VW = wopi_pkg::DVS_W;
  localparam int KW = wopi_pkg::KPART_W;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_MLO    = 15'b000000000000010,
    ST_MHI    = 15'b000000000000100,
    ST_MADD   = 15'b000000000001000,
    ST_DSTART = 15'b000000000010000,
    ST_DWAIT  = 15'b000000000100000,
    ST_CWAIT1 = 15'b000000001000000,
    ST_M0     = 15'b000000010000000,
    ST_M1     = 15'b000000100000000,
    ST_M2     = 15'b000001000000000,
    ST_M3     = 15'b000010000000000,
    ST_M4     = 15'b000100000000000,
    ST_M5     = 15'b001000000000000,
    ST_CWAIT2 = 15'b010000000000000,
    ST_OUT    = 15'b100000000000000
  } state_t;

  state_t state;

  // pose state
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] head;

  // working registers
  wopi_pkg::work_t      w;
  logic [SW-1:0]        mag;
  logic                 neg;
  logic                 pass;
  logic                 zero_div;
  logic [31:0]          dth;
  logic signed [31:0]   c_r;
  logic signed [31:0]   s_r;
  logic signed [PW-1:0] prod;
  logic [NW-1:0]        acc_div;
  logic [63:0]          acc_x;
  logic [63:0]          acc_y;
  logic                 out_valid;

  // combinational helpers
  logic signed [SW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic [DNW-1:0]       denom;
  logic [VW-1:0]        dvs;
  logic                 div_start;
  logic                 div_done;
  logic [31:0]          div_q;
  logic [31:0]          q_val;
  logic [31:0]          q_signed;
  logic                 cor_start;
  logic [31:0]          cor_angle;
  logic                 cor_done;
  logic signed [31:0]   cor_c;
  logic signed [31:0]   cor_s;
  logic [31:0]          head_new;
  logic [31:0]          half_h;
  logic [63:0]          rnd_x;
  logic [63:0]          rnd_y;
  logic                 slot_free;

  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;

  // divisor: 2T or 4(T+W) on the first pass, 4T for the half-step heading
  always_comb begin
    if (pass)           denom = DNW'({track_span, 2'b00});
    else if (w.mecanum) denom = DNW'({24'(track_span) + 24'(base_extra), 2'b00});
    else                denom = DNW'({track_span, 1'b0});
  end
  assign dvs = {denom, 16'b0};

  // shared multiplier operands
  always_comb begin
    unique case (state)
      ST_MLO:  begin mul_a = $signed(mag); mul_b = BW'(wopi_pkg::K_LO); end
      ST_MHI:  begin mul_a = $signed(mag); mul_b = BW'(wopi_pkg::K_HI); end
      ST_M0:   begin mul_a = w.s_all;      mul_b = c_r;                 end
      ST_M1:   begin mul_a = w.ym;         mul_b = s_r;                 end
      ST_M2:   begin mul_a = w.s_all;      mul_b = s_r;                 end
      ST_M3:   begin mul_a = w.ym;         mul_b = c_r;                 end
      default: begin mul_a = '0;           mul_b = '0;                  end
    endcase
  end

  assign q_val    = zero_div ? 32'd0 : div_q;
  assign q_signed = neg ? 32'd0 - q_val : q_val;
  assign head_new = head + dth;
  assign half_h   = (head_new == 32'h80000000) ? 32'h40000000
                                               : {head_new[31], head_new[31:1]};
  assign rnd_x    = acc_x + 64'h80000000;
  assign rnd_y    = acc_y + 64'h80000000;
  assign div_start = (state == ST_DSTART) && !zero_div;

  // cordic requests: travel angle, then half heading
  always_comb begin
    cor_start = 1'b0;
    cor_angle = head;
    if (state == ST_DWAIT && (zero_div || div_done)) begin
      if (!pass && w.mecanum) begin
        cor_start = 1'b1;
        cor_angle = head;
      end else if (pass) begin
        cor_start = 1'b1;
        cor_angle = head + q_signed;
      end
    end else if (state == ST_M5) begin
      cor_start = 1'b1;
      cor_angle = half_h;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos_x     <= '0;
      pos_y     <= '0;
      head      <= '0;
      pass      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pass  <= 1'b0;
            state <= ST_MLO;
          end
        end
        ST_MLO:    state <= ST_MHI;
        ST_MHI:    state <= ST_MADD;
        ST_MADD:   state <= ST_DSTART;
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (zero_div || div_done) begin
            if (!pass && !w.mecanum) begin
              pass  <= 1'b1;
              state <= ST_MLO;
            end else begin
              state <= ST_CWAIT1;
            end
          end
        end
        ST_CWAIT1: if (cor_done) state <= ST_M0;
        ST_M0:     state <= ST_M1;
        ST_M1:     state <= ST_M2;
        ST_M2:     state <= ST_M3;
        ST_M3:     state <= ST_M4;
        ST_M4:     state <= ST_M5;
        ST_M5: begin
          pos_x <= pos_x + rnd_x[63:32];
          pos_y <= pos_y + rnd_y[63:32];
          head  <= head_new;
          state <= ST_CWAIT2;
        end
        ST_CWAIT2: if (cor_done) state <= ST_OUT;
        ST_OUT: begin
          if (slot_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= $signed(PW'(mul_a)) * $signed(PW'(mul_b));
    unique case (state)
      ST_IDLE: begin
        w   <= q_data;
        neg <= q_data.num[SW-1];
        mag <= q_data.num[SW-1] ? SW'(-q_data.num) : SW'(q_data.num);
      end
      ST_MHI:  acc_div <= NW'(prod[59:0]);
      ST_MADD: begin
        acc_div  <= acc_div + (NW'(prod[59:0]) << KW) + NW'(dvs >> 1);
        zero_div <= (denom == '0);
      end
      ST_DWAIT: if ((zero_div || div_done) && !pass) dth <= q_signed;
      ST_CWAIT1: if (cor_done) begin
        c_r <= cor_c;
        s_r <= cor_s;
      end
      ST_M1: acc_x <= prod[63:0];
      ST_M2: acc_x <= acc_x - prod[63:0];
      ST_M3: acc_y <= prod[63:0];
      ST_M4: acc_y <= acc_y + prod[63:0];
      // cordic holds the half-heading terms until its next start
      ST_OUT: if (slot_free) begin
        pose_x   <= pos_x;
        pose_y   <= pos_y;
        heading  <= head;
        orient_z <= cor_s;
        orient_w <= cor_c;
      end
      default: ;
    endcase
  end

  wopi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_div),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  wopi_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_q (cor_c),
    .sin_q (cor_s)
  );

endmodule

/* src/wheel_odometry_pose_integrator.sv */
// wheel_odometry_pose_integrator: top level, configuration registers and
// the front/back split. Depends on wopi_pkg, wopi_front, wopi_back.
//
//   channel   handshake          payload
//   input     push / full        sequence_req, four totals, four steps
//   result    empty / pop        pose_x, pose_y, heading, orient_z, orient_w
//   config    cfg_write          cfg_index, cfg_data (no wait)
//
// Each angle division works one bit a cycle over an 82-bit dividend (one
// division mecanum, two differential); each item makes two cordic passes,
// plus setup and multiply steps on one shared multiplier. A zero divisor
// skips its division. Reset is synchronous; it clears the pose and the
// previous report and sets the configuration to its defaults. The front takes
// up to two words ahead of the back, and a finished result waits in its output
// register while the next item proceeds; the back stalls only if that register
// is still full.
`timescale 1ns / 1ps
module wheel_odometry_pose_integrator #(
  parameter int DIST_WIDTH = wopi_pkg::DIST_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        sequence_req,
  input  logic signed [31:0] left_front_total,
  input  logic signed [31:0] left_back_total,
  input  logic signed [31:0] right_front_total,
  input  logic signed [31:0] right_back_total,
  input  logic signed [31:0] left_front_step,
  input  logic signed [31:0] left_back_step,
  input  logic signed [31:0] right_front_step,
  input  logic signed [31:0] right_back_step,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] orient_z,
  output logic signed [31:0] orient_w
);

  logic [22:0]     track_span;
  logic [22:0]     base_extra;
  logic            mecanum_mode;
  logic            q_valid;
  logic            q_pop;
  wopi_pkg::work_t q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      track_span   <= 23'd32768;
      base_extra   <= '0;
      mecanum_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wopi_pkg::REG_TRACK_SPAN:   track_span   <= cfg_data;
        wopi_pkg::REG_BASE_EXTRA:   base_extra   <= cfg_data;
        wopi_pkg::REG_MECANUM_MODE: mecanum_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wopi_front #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .mecanum_mode      (mecanum_mode),
    .sequence_req      (sequence_req),
    .left_front_total  (left_front_total),
    .left_back_total   (left_back_total),
    .right_front_total (right_front_total),
    .right_back_total  (right_back_total),
    .left_front_step   (left_front_step),
    .left_back_step    (left_back_step),
    .right_front_step  (right_front_step),
    .right_back_step   (right_back_step),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop)
  );

  wopi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .track_span  (track_span),
    .base_extra  (base_extra),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .pose_x      (pose_x),
    .pose_y      (pose_y),
    .heading     (heading),
    .orient_z    (orient_z),
    .orient_w    (orient_w)
  );

endmodule

/* dv/testbench.sv */
// testbench: self-checking bench for the wheel odometry pose integrator,
// with a built-in pose predictor, queue driver and result monitor.
// Depends on wopi_pkg and wheel_odometry_pose_integrator.
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_WORDS = 210;

  typedef struct {
    bit [31:0]       seq;
    bit [3:0][31:0]  tot;
    bit [3:0][31:0]  stp;
  } report_t;

  typedef bit [4:0][31:0] pose_t;

  logic clk, rst;
  logic cfg_write;
  wopi_pkg::reg_index_t cfg_index;
  logic [22:0] cfg_data;
  logic push, full, empty, pop;
  logic [31:0] sequence_req;
  logic signed [31:0] left_front_total, left_back_total, right_front_total, right_back_total;
  logic signed [31:0] left_front_step, left_back_step, right_front_step, right_back_step;
  logic signed [31:0] pose_x, pose_y, heading, orient_z, orient_w;

  wheel_odometry_pose_integrator u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .push, .full,
    .sequence_req, .left_front_total, .left_back_total, .right_front_total,
    .right_back_total, .left_front_step, .left_back_step, .right_front_step,
    .right_back_step, .empty, .pop, .pose_x, .pose_y, .heading, .orient_z, .orient_w
  );

  report_t reports_pending[$];
  pose_t   poses_expected[$];
  int      fails = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      word_in, word_out;

  // predictor copy of configuration and state
  bit [22:0]      m_track, m_wheel;
  bit             m_mecanum;
  bit             m_have_prev;
  bit [31:0]      m_prev_seq;
  bit [3:0][31:0] m_prev_tot;
  bit [31:0]      m_px, m_py, m_head;

  // binary-angle arctangents of 2^-i
  localparam longint ATAN_BAM [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  // radian ratio to binary angle, rounded half away from zero, mod 2^32
  function automatic bit [31:0] ratio_to_bam(input longint num, input bit [63:0] den);
    bit [127:0] p, dd;
    bit [127:0] q;
    bit [63:0]  mag;
    if (den == 0) return 32'd0;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    dd = {64'd0, den} << 16;
    p = 128'(mag) * 128'd44798133900178 + (dd >> 1);
    q = p / dd;
    return (num < 0) ? 32'd0 - q[31:0] : q[31:0];
  endfunction

  // cordic cosine and sine in q1.30
  function automatic void trig_q30(input bit [31:0] ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang > 32'h40000000 && ang < 32'hC0000000) begin
      ang += 32'h80000000;
      flip = 1;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_BAM[i];
      end else begin
        x += ys; y -= xs; z += ATAN_BAM[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = (x > 1073741824) ? 1073741824 : (x < -1073741824) ? -1073741824 : x;
    s = (y > 1073741824) ? 1073741824 : (y < -1073741824) ? -1073741824 : y;
  endfunction

  function automatic bit [31:0] round_q32(input longint prod);
    bit [63:0] p;
    p = 64'(prod) + 64'h80000000;
    return p[63:32];
  endfunction

  // advance the pose by one report
  function automatic pose_t integrate_report(input report_t r);
    longint d[4], s_all, ym, nm, c, sn;
    bit use_tot;
    bit [31:0] dth, hmid, half_h;
    pose_t o;
    use_tot = m_have_prev && (r.seq - m_prev_seq) != 32'd1;
    for (int k = 0; k < 4; k++) begin
      d[k] = use_tot ? longint'($signed(r.tot[k] - m_prev_tot[k])) : longint'($signed(r.stp[k]));
      m_prev_tot[k] = r.tot[k];
    end
    m_prev_seq = r.seq;
    m_have_prev = 1;
    s_all = d[0] + d[1] + d[2] + d[3];
    if (m_mecanum) begin
      ym = -d[0] + d[1] - d[2] + d[3];
      nm = -d[0] + d[1] + d[2] - d[3];
      dth = ratio_to_bam(nm, 4 * (64'(m_track) + 64'(m_wheel)));
      trig_q30(m_head, c, sn);
      m_px += round_q32(s_all * c - ym * sn);
      m_py += round_q32(s_all * sn + ym * c);
    end else begin
      nm = d[2] + d[3] - d[0] - d[1];
      dth = ratio_to_bam(nm, 2 * 64'(m_track));
      hmid = m_head + ratio_to_bam(nm, 4 * 64'(m_track));
      trig_q30(hmid, c, sn);
      m_px += round_q32(s_all * c);
      m_py += round_q32(s_all * sn);
    end
    m_head += dth;
    // half turn counts as +pi
    if (m_head == 32'h80000000) half_h = 32'h40000000;
    else half_h = $signed(m_head) >>> 1;
    trig_q30(half_h, c, sn);
    o[0] = m_px; o[1] = m_py; o[2] = m_head; o[3] = sn[31:0]; o[4] = c[31:0];
    return o;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // predictor, scoreboard and cycle limit
  always @(posedge clk) begin
    pose_t exp_pose, got;
    string names [5];
    names = '{"pose_x", "pose_y", "heading", "orient_z", "orient_w"};
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("wheel_odometry_pose_integrator: mismatch");
      $finish;
    end else begin
      word_in = !rst && push && !full;
      word_out = !rst && pop && !empty;
      if (!rst && cfg_write) begin
        case (cfg_index)
          wopi_pkg::REG_TRACK_SPAN:   m_track = cfg_data;
          wopi_pkg::REG_BASE_EXTRA:   m_wheel = cfg_data;
          wopi_pkg::REG_MECANUM_MODE: m_mecanum = cfg_data[0];
          default: ;
        endcase
      end
      if (word_in) begin
        report_t r;
        r.seq = sequence_req;
        r.tot = {right_back_total, right_front_total, left_back_total, left_front_total};
        r.stp = {right_back_step, right_front_step, left_back_step, left_front_step};
        poses_expected.push_back(integrate_report(r));
      end
      if (word_out) begin
        got = {orient_w, orient_z, heading, pose_y, pose_x};
        if (poses_expected.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, actual %h", $time, got);
        end else begin
          exp_pose = poses_expected.pop_front();
          for (int f = 0; f < 5; f++)
            if (exp_pose[f] !== got[f]) begin
              fails++;
              $display("%0t: %s expected %h actual %h", $time, names[f], exp_pose[f], got[f]);
            end
        end
      end
    end
  end

  // driver: presents pending reports and random pops
  always @(negedge clk) begin
    if (!rst) begin
      if (!push || word_in) begin
        if (reports_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          report_t r;
          r = reports_pending.pop_front();
          push <= 1;
          sequence_req <= r.seq;
          left_front_total <= r.tot[0]; left_back_total <= r.tot[1];
          right_front_total <= r.tot[2]; right_back_total <= r.tot[3];
          left_front_step <= r.stp[0]; left_back_step <= r.stp[1];
          right_front_step <= r.stp[2]; right_back_step <= r.stp[3];
        end else begin
          push <= 0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // generator state
  bit [31:0]      g_seq;
  bit [3:0][31:0] g_tot;

  task automatic add_report(input bit [31:0] seq, input bit [3:0][31:0] tot,
                            input bit [3:0][31:0] stp);
    report_t r;
    r.seq = seq; r.tot = tot; r.stp = stp;
    reports_pending.push_back(r);
    g_seq = seq;
    g_tot = tot;
  endtask

  task automatic add_random_report();
    bit [31:0] seq, mv;
    bit [3:0][31:0] tot, stp;
    int r;
    r = $urandom_range(99);
    if (r < 75) seq = g_seq + 1;
    else if (r < 85) seq = g_seq;
    else if (r < 95) seq = g_seq + $urandom_range(2, 50);
    else seq = $urandom;
    for (int k = 0; k < 4; k++) begin
      mv = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(2097152)) - 32'd1048576;
      tot[k] = ($urandom_range(49) == 0) ? $urandom : g_tot[k] + mv;
      stp[k] = ($urandom_range(9) == 0) ? $urandom : mv;
    end
    add_report(seq, tot, stp);
  endtask

  task automatic write_reg(input wopi_pkg::reg_index_t idx, input bit [22:0] val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (reports_pending.size() != 0 || poses_expected.size() != 0 || push);
    repeat (8) @(posedge clk);
  endtask

  // stimulus sequencing
  initial begin
    bit [22:0] cfg_track [8] = '{32768, 655, 6553600, 655, 0, 0, 23'h7FFFFF, 6553600};
    bit [22:0] cfg_wheel [8] = '{0, 0, 6553600, 0, 0, 0, 23'h7FFFFF, 0};
    bit        cfg_mode  [8] = '{0, 0, 1, 1, 0, 1, 1, 0};
    rst = 1;
    push = 0; pop = 0; cfg_write = 0;
    cfg_index = wopi_pkg::REG_TRACK_SPAN; cfg_data = '0;
    sequence_req = '0;
    left_front_total = '0; left_back_total = '0; right_front_total = '0; right_back_total = '0;
    left_front_step = '0; left_back_step = '0; right_front_step = '0; right_back_step = '0;
    m_track = 32768; m_wheel = 0; m_mecanum = 0;
    m_have_prev = 0; m_prev_seq = 0; m_prev_tot = '0;
    m_px = 0; m_py = 0; m_head = 0;
    g_seq = 0; g_tot = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(wopi_pkg::REG_TRACK_SPAN, cfg_track[ph]);
      write_reg(wopi_pkg::REG_BASE_EXTRA, cfg_wheel[ph]);
      write_reg(wopi_pkg::REG_MECANUM_MODE, 23'(cfg_mode[ph]));
      @(negedge clk);
      cfg_write <= 0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (ph == 0 || ph == 2) begin
        // in the first phase the first report uses steps whatever its sequence
        add_report(32'hFFFFFFF0, {4{32'h7FFFFFFF}}, '0);
        add_report(32'hFFFFFFF1, '0, {4{32'h7FFFFFFF}});
        add_report(32'hFFFFFFF2, '0, {4{32'h80000000}});
        add_report(32'hFFFFFFF3, '0, {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000});
        add_report(32'hFFFFFFF4, '0, {32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF});
        add_report(32'hFFFFFFFF, {4{32'h7FFFFFFF}}, '0);
        // sequence wraps to zero: one ahead, steps used
        add_report(32'h00000000, {4{32'h80000000}}, {32'h00010000, 32'h00020000, 32'h0, 32'h0});
        // repeated sequence: total differences wrap
        add_report(32'h00000000, {4{32'h7FFFFFFF}}, {4{32'h12345678}});
        add_report(32'h00000005, {32'h0, 32'h00010000, 32'hFFFF0000, 32'h80000000}, '0);
        add_report(32'h00000006, '0, {32'h00000001, 32'hFFFFFFFF, 32'h00008000, 32'hFFFF8000});
        add_report(32'hA5A5A5A5, {4{32'h5A5A5A5A}}, {4{32'hFFFFFFFF}});
        add_report(32'hA5A5A5A6, {4{32'h5A5A5A5A}}, '0);
      end
      for (int i = 0; i < PHASE_WORDS; i++) add_random_report();
      wait_idle();
    end

    if (fails == 0) $display("wheel_odometry_pose_integrator: match");
    else $display("wheel_odometry_pose_integrator: mismatch");
    $finish;
  end

endmodule
